>>> hdl/tsc_pkg.sv
// tsc_pkg: shared types, microcode formats and constants for the
// timestamp-to-calendar converter. No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int STEP_W    = 5;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 40;
    localparam int DAYS_W    = 16;
    localparam int DOY_W     = 9;
    localparam int MIDX_W    = 4;

    localparam logic [DOY_W-1:0]  LEAP_DAY_DOY   = 9'd59;
    localparam logic [MIDX_W-1:0] MONTH_LAST_IDX = 4'd11;
    localparam logic [MIDX_W-1:0] MONTH_FEB_IDX  = 4'd1;
    localparam logic [2:0]        WD_SUNDAY      = 3'd7;
    localparam logic [31:0]       EPOCH_WD_BIAS  = 32'd6;

    // Micro-operations of the datapath
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_MUL,
        UOP_REM,
        UOP_WD_PREP,
        UOP_YR_PREP,
        UOP_YR_SET,
        UOP_START,
        UOP_DOY,
        UOP_LEAP,
        UOP_WALK,
        UOP_DONE
    } t_uop;

    // Constant divisor select
    typedef enum logic [1:0] {
        DSEL_60,
        DSEL_24,
        DSEL_7,
        DSEL_1461
    } t_dsel;

    // Destination of a remainder
    typedef enum logic [1:0] {
        DST_SEC,
        DST_MIN,
        DST_HR,
        DST_WD
    } t_dest;

    // Sequencing condition
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WALK,
        COND_FINISH
    } t_cond;

    typedef struct packed {
        t_uop              op;
        t_dsel             dsel;
        t_dest             dest;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [2:0] weekday;
        logic [7:0] year_offset;
        logic [3:0] month;
        logic [4:0] day_of_month;
    } t_result;

    // q = (x * M) >> S is exact for every x the program feeds in
    function automatic logic [31:0] div_recip(input t_dsel sel);
        logic [31:0] m;
        case (sel)
            DSEL_60:   m = 32'd2290649225;
            DSEL_24:   m = 32'd2863311531;
            DSEL_7:    m = 32'd613566757;
            DSEL_1461: m = 32'd2939745;
            default:   m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] div_shift(input t_dsel sel);
        logic [5:0] s;
        case (sel)
            DSEL_60:   s = 6'd37;
            DSEL_24:   s = 6'd36;
            DSEL_7:    s = 6'd32;
            DSEL_1461: s = 6'd32;
            default:   s = 6'd32;
        endcase
        return s;
    endfunction

    function automatic logic [10:0] div_value(input t_dsel sel);
        logic [10:0] d;
        case (sel)
            DSEL_60:   d = 11'd60;
            DSEL_24:   d = 11'd24;
            DSEL_7:    d = 11'd7;
            DSEL_1461: d = 11'd1461;
            default:   d = 11'd1;
        endcase
        return d;
    endfunction

    // Non-leap month lengths, January at index 0
    function automatic logic [4:0] month_len(input logic [MIDX_W-1:0] idx);
        logic [4:0] n;
        case (idx)
            4'd1:    n = 5'd28;
            4'd3:    n = 5'd30;
            4'd5:    n = 5'd30;
            4'd8:    n = 5'd30;
            4'd10:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/tsc_urom.sv
// tsc_urom: microcode program of the converter, one control word per step.
// Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_urom (
    input  logic [tsc_pkg::STEP_W-1:0] i_step,
    output tsc_pkg::t_uword            o_uword
);

    always_comb begin
        o_uword.op     = tsc_pkg::UOP_NOP;
        o_uword.dsel   = tsc_pkg::DSEL_60;
        o_uword.dest   = tsc_pkg::DST_SEC;
        o_uword.cond   = tsc_pkg::COND_NEXT;
        o_uword.target = '0;
        case (i_step)
            5'd0: begin
                o_uword.op = tsc_pkg::UOP_MUL;
            end
            5'd1: begin
                o_uword.op = tsc_pkg::UOP_REM;
            end
            5'd2: begin
                o_uword.op = tsc_pkg::UOP_MUL;
            end
            5'd3: begin
                o_uword.op   = tsc_pkg::UOP_REM;
                o_uword.dest = tsc_pkg::DST_MIN;
            end
            5'd4: begin
                o_uword.op   = tsc_pkg::UOP_MUL;
                o_uword.dsel = tsc_pkg::DSEL_24;
            end
            5'd5: begin
                o_uword.op   = tsc_pkg::UOP_REM;
                o_uword.dsel = tsc_pkg::DSEL_24;
                o_uword.dest = tsc_pkg::DST_HR;
            end
            5'd6: begin
                o_uword.op = tsc_pkg::UOP_WD_PREP;
            end
            5'd7: begin
                o_uword.op   = tsc_pkg::UOP_MUL;
                o_uword.dsel = tsc_pkg::DSEL_7;
            end
            5'd8: begin
                o_uword.op   = tsc_pkg::UOP_REM;
                o_uword.dsel = tsc_pkg::DSEL_7;
                o_uword.dest = tsc_pkg::DST_WD;
            end
            5'd9: begin
                o_uword.op = tsc_pkg::UOP_YR_PREP;
            end
            5'd10: begin
                o_uword.op   = tsc_pkg::UOP_MUL;
                o_uword.dsel = tsc_pkg::DSEL_1461;
            end
            5'd11: begin
                o_uword.op   = tsc_pkg::UOP_YR_SET;
                o_uword.dsel = tsc_pkg::DSEL_1461;
            end
            5'd12: begin
                o_uword.op = tsc_pkg::UOP_START;
            end
            5'd13: begin
                o_uword.op = tsc_pkg::UOP_DOY;
            end
            5'd14: begin
                o_uword.op = tsc_pkg::UOP_LEAP;
            end
            5'd15: begin
                o_uword.op     = tsc_pkg::UOP_WALK;
                o_uword.cond   = tsc_pkg::COND_WALK;
                o_uword.target = 5'd15;
            end
            5'd16: begin
                o_uword.op   = tsc_pkg::UOP_DONE;
                o_uword.cond = tsc_pkg::COND_FINISH;
            end
            default: begin
                o_uword.cond = tsc_pkg::COND_FINISH;
            end
        endcase
    end

endmodule

>>> hdl/tsc_dpath.sv
// tsc_dpath: datapath of the converter (reciprocal multiplier, remainder,
// year start, month walk), driven one control word per cycle while busy. Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_dpath (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [tsc_pkg::IN_W-1:0]   i_seconds_count,
    input  logic                       i_run,
    input  tsc_pkg::t_uword            i_uword,
    output logic                       o_walk_go,
    output tsc_pkg::t_result           o_result
);

    logic [31:0]                  r_acc, n_acc;
    logic [63:0]                  r_prod, n_prod;
    logic [tsc_pkg::DAYS_W-1:0]   r_days, n_days;
    logic [tsc_pkg::DAYS_W-1:0]   r_start, n_start;
    logic [tsc_pkg::DOY_W-1:0]    r_doy, n_doy;
    logic [tsc_pkg::MIDX_W-1:0]   r_midx, n_midx;
    logic                         r_leap, n_leap;
    logic [5:0]                   r_sec, n_sec;
    logic [5:0]                   r_min, n_min;
    logic [4:0]                   r_hr, n_hr;
    logic [2:0]                   r_wd, n_wd;
    logic [7:0]                   r_yr, n_yr;

    logic [31:0]                  w_quo;
    logic [42:0]                  w_qd;
    logic [31:0]                  w_rem;
    logic [tsc_pkg::DOY_W-1:0]    w_mlen;
    logic                         w_leap;

    assign w_quo  = 32'(r_prod >> tsc_pkg::div_shift(i_uword.dsel));
    assign w_qd   = 43'(w_quo) * 43'(tsc_pkg::div_value(i_uword.dsel));
    assign w_rem  = r_acc - w_qd[31:0];
    assign w_mlen = tsc_pkg::DOY_W'(tsc_pkg::month_len(r_midx));
    assign w_leap = (r_yr[1:0] == 2'd0) && (r_doy > tsc_pkg::LEAP_DAY_DOY);

    assign o_walk_go = (r_midx < tsc_pkg::MONTH_LAST_IDX) && (r_doy > w_mlen);

    always_comb begin
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_days  = r_days;
        n_start = r_start;
        n_doy   = r_doy;
        n_midx  = r_midx;
        n_leap  = r_leap;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hr    = r_hr;
        n_wd    = r_wd;
        n_yr    = r_yr;
        if (i_load) begin
            n_acc = i_seconds_count;
        end else if (i_run) begin
            case (i_uword.op)
                tsc_pkg::UOP_MUL: begin
                    n_prod = 64'(r_acc) * 64'(tsc_pkg::div_recip(i_uword.dsel));
                end
                tsc_pkg::UOP_REM: begin
                    n_acc = w_quo;
                    case (i_uword.dest)
                        tsc_pkg::DST_SEC: n_sec = w_rem[5:0];
                        tsc_pkg::DST_MIN: n_min = w_rem[5:0];
                        tsc_pkg::DST_HR: begin
                            n_hr   = w_rem[4:0];
                            n_days = w_quo[tsc_pkg::DAYS_W-1:0];
                        end
                        tsc_pkg::DST_WD: begin
                            n_wd = (w_rem[2:0] == 3'd0) ? tsc_pkg::WD_SUNDAY : w_rem[2:0];
                        end
                        default: n_sec = r_sec;
                    endcase
                end
                tsc_pkg::UOP_WD_PREP: begin
                    n_acc = 32'(r_days) + tsc_pkg::EPOCH_WD_BIAS;
                end
                tsc_pkg::UOP_YR_PREP: begin
                    n_acc = 32'(r_days) << 2;
                end
                tsc_pkg::UOP_YR_SET: begin
                    n_yr = w_quo[7:0];
                end
                tsc_pkg::UOP_START: begin
                    // first day of the year: 365*y + ceil(y/4)
                    n_start = tsc_pkg::DAYS_W'(17'(r_yr) * 17'd365)
                            + tsc_pkg::DAYS_W'((9'(r_yr) + 9'd3) >> 2);
                end
                tsc_pkg::UOP_DOY: begin
                    n_doy = tsc_pkg::DOY_W'(r_days - r_start + 16'd1);
                end
                tsc_pkg::UOP_LEAP: begin
                    // fold Feb 29 away, give it back if the walk ends in February
                    n_leap = w_leap;
                    n_midx = '0;
                    if (w_leap) begin
                        n_doy = r_doy - 9'd1;
                    end
                end
                tsc_pkg::UOP_WALK: begin
                    if (o_walk_go) begin
                        n_doy  = r_doy - w_mlen;
                        n_midx = r_midx + 4'd1;
                    end
                end
                default: n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_days  <= n_days;
        r_start <= n_start;
        r_doy   <= n_doy;
        r_midx  <= n_midx;
        r_leap  <= n_leap;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hr    <= n_hr;
        r_wd    <= n_wd;
        r_yr    <= n_yr;
    end

    always_comb begin
        o_result.seconds      = r_sec;
        o_result.minutes      = r_min;
        o_result.hours        = r_hr;
        o_result.weekday      = r_wd;
        o_result.year_offset  = r_yr;
        o_result.month        = r_midx + 4'd1;
        o_result.day_of_month = r_doy[4:0]
            + ((r_leap && (r_midx == tsc_pkg::MONTH_FEB_IDX)) ? 5'd1 : 5'd0);
    end

endmodule

>>> hdl/timestamp_to_calendar.sv
// Each request runs the microcode program step by step; the month walk step
// repeats for each of the 0..11 months walked past, which sets how long it takes.
// The block takes no new request until the sequencer has loaded the result
// into the output register and is back in its ready state.
// Reset (synchronous, active low) idles the sequencer and empties the output
// register; datapath registers hold garbage until the next request.
`timescale 1ns / 1ps

module timestamp_to_calendar (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [tsc_pkg::IN_W-1:0]     s_axis_tdata,   // [31:0] seconds_count
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [5:0] seconds, [11:6] minutes, [16:12] hours, [19:17] weekday,
    // [27:20] year_offset, [31:28] month, [36:32] day_of_month, [39:37] zero
    output logic [tsc_pkg::OUT_W-1:0]    m_axis_tdata
);

    // Sequencer state: busy flag and microcode step counter
    logic                         r_busy, n_busy;
    logic [tsc_pkg::STEP_W-1:0]   r_step, n_step;

    // Output register, parts the result from the next request
    logic                         r_out_valid, n_out_valid;
    logic [tsc_pkg::OUT_W-1:0]    r_out_data, n_out_data;

    tsc_pkg::t_uword              w_uword;
    tsc_pkg::t_result             w_result;
    logic                         w_walk_go;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_finish;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && !r_busy;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // The final step waits here until the output register can take the result
    assign w_finish      = r_busy && (w_uword.cond == tsc_pkg::COND_FINISH) && w_out_free;

    tsc_urom u_urom (
        .i_step  (r_step),
        .o_uword (w_uword)
    );

    tsc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_load          (w_accept),
        .i_seconds_count (s_axis_tdata),
        .i_run           (r_busy),
        .i_uword         (w_uword),
        .o_walk_go       (w_walk_go),
        .o_result        (w_result)
    );

    // Step counter: advance, loop on the month walk, stall at the end
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (r_busy) begin
            case (w_uword.cond)
                tsc_pkg::COND_NEXT: begin
                    n_step = r_step + 5'd1;
                end
                tsc_pkg::COND_WALK: begin
                    n_step = w_walk_go ? w_uword.target : r_step + 5'd1;
                end
                tsc_pkg::COND_FINISH: begin
                    if (w_out_free) begin
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    // Output register: load on finish, drop valid once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_finish) begin
            n_out_valid = 1'b1;
            n_out_data  = {3'b000,
                           w_result.day_of_month,
                           w_result.month,
                           w_result.year_offset,
                           w_result.weekday,
                           w_result.hours,
                           w_result.minutes,
                           w_result.seconds};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload holds without reset
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> bench/tsc_calendar_checker.sv
// tsc_calendar_checker: watches both stream channels of timestamp_to_calendar,
// predicts the calendar fields of every request and compares each result.
// Depends on tsc_pkg for widths and the result record.
`timescale 1ns / 1ps

module tsc_calendar_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic                      i_req_ready,
    input  logic [tsc_pkg::IN_W-1:0]  i_req_data,   // [31:0] seconds_count
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    // [5:0] seconds, [11:6] minutes, [16:12] hours, [19:17] weekday,
    // [27:20] year_offset, [31:28] month, [36:32] day_of_month, [39:37] zero
    input  logic [tsc_pkg::OUT_W-1:0] i_res_data,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    // Non-leap month lengths, January first
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

    tsc_pkg::t_result dates_due [$];
    int               fail_count = 0;
    int               outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    // Break a second count since 2000-01-01 into calendar fields
    function automatic tsc_pkg::t_result calendar_of(input logic [31:0] count);
        int unsigned      rest, days, wd, yr, first_day, yday, idx;
        logic             leap_fix;
        tsc_pkg::t_result r;
        r.seconds = 6'(count % 60);
        rest      = count / 60;
        r.minutes = 6'(rest % 60);
        rest      = rest / 60;
        r.hours   = 5'(rest % 24);
        days      = rest / 24;
        // day zero is a Saturday
        wd = (days + 6) % 7;
        r.weekday = (wd == 0) ? tsc_pkg::WD_SUNDAY : 3'(wd);
        yr        = (4 * days) / 1461;
        first_day = 365 * yr + (yr + 3) / 4;
        yday      = days - first_day + 1;
        // drop Feb 29 from the day of year, give it back if we land in February
        leap_fix  = ((yr % 4) == 0) && (yday > 59);
        if (leap_fix)
            yday = yday - 1;
        idx = 0;
        while (idx < 11 && yday > MONTH_DAYS[idx]) begin
            yday = yday - MONTH_DAYS[idx];
            idx++;
        end
        r.year_offset  = 8'(yr);
        r.month        = 4'(idx + 1);
        r.day_of_month = 5'(yday + ((leap_fix && idx == 1) ? 1 : 0));
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        tsc_pkg::t_result want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                dates_due.push_back(calendar_of(i_req_data));
                outstanding++;
            end
            if (i_res_valid && i_res_ready) begin
                if (dates_due.size() == 0) begin
                    $error("result with no request outstanding: tdata=%h", i_res_data);
                    fail_count++;
                end else begin
                    want = dates_due.pop_front();
                    outstanding--;
                    check_field("seconds",      want.seconds,      i_res_data[5:0]);
                    check_field("minutes",      want.minutes,      i_res_data[11:6]);
                    check_field("hours",        want.hours,        i_res_data[16:12]);
                    check_field("weekday",      want.weekday,      i_res_data[19:17]);
                    check_field("year_offset",  want.year_offset,  i_res_data[27:20]);
                    check_field("month",        want.month,        i_res_data[31:28]);
                    check_field("day_of_month", want.day_of_month, i_res_data[36:32]);
                    check_field("padding",      0,                 i_res_data[39:37]);
                end
            end
        end
    end

endmodule

>>> bench/tb_timestamp_to_calendar.sv
// tb_timestamp_to_calendar: drives second counts into timestamp_to_calendar
// with random gaps and result stalls; checking lives in tsc_calendar_checker.
// Depends on tsc_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_timestamp_to_calendar;

    localparam int RANDOM_ITEMS   = 550;
    localparam int LAST_FULL_DAY  = 49709;   // last day whose 86400 s fit in 32 bits
    localparam int PRESSURE_AFTER = 40;      // results taken before the long hold-off
    localparam int PRESSURE_LEN   = 500;
    localparam int DRAIN_CYCLES   = 40;

    // First day of each month in a non-leap year
    localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151,
                                        181, 212, 243, 273, 304, 334};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [tsc_pkg::IN_W-1:0]  s_axis_tdata = '0;     // [31:0] seconds_count
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [5:0] seconds, [11:6] minutes, [16:12] hours, [19:17] weekday,
    // [27:20] year_offset, [31:28] month, [36:32] day_of_month, [39:37] zero
    logic [tsc_pkg::OUT_W-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int results_taken = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    timestamp_to_calendar uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tsc_calendar_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Gap or stall length: mostly short, now and then long
    function automatic int pick_pause(input int min_len);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return min_len;
        else if (roll < 9)
            return $urandom_range(min_len + 1, min_len + 4);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random second count: raw 32-bit values, random day and time, or
    // a time right at a month or year boundary
    function automatic logic [31:0] random_stamp();
        int               roll, yr, mon, day, sod;
        longint unsigned  total;
        roll = $urandom_range(0, 9);
        if (roll < 3)
            return $urandom();
        if (roll < 7) begin
            day = $urandom_range(0, LAST_FULL_DAY);
        end else begin
            yr  = $urandom_range(0, 135);
            mon = $urandom_range(0, 11);
            day = 365 * yr + (yr + 3) / 4 + MONTH_START[mon]
                  + (((yr % 4) == 0 && mon >= 2) ? 1 : 0)
                  + $urandom_range(0, 1) - 1;
            if (day < 0)
                day = 0;
        end
        case ($urandom_range(0, 3))
            0:       sod = 0;
            1:       sod = 86399;
            default: sod = $urandom_range(0, 86399);
        endcase
        total = longint'(day) * 86400 + sod;
        return total[31:0];
    endfunction

    // Offer one request, hold it until the block takes it
    task automatic send_stamp(input logic [31:0] stamp, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Receiver: alternate runs of ready with stalls; once, hold off for a long
    // stretch so the block fills up and stalls its input
    initial begin
        int  run_len, stall_len, roll;
        bit  pressure_done;
        pressure_done = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!pressure_done && results_taken >= PRESSURE_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_LEN) @(posedge i_clk);
                pressure_done = 1'b1;
            end
            roll = $urandom_range(0, 9);
            if (roll < 6)
                run_len = $urandom_range(1, 8);
            else if (roll < 9)
                run_len = $urandom_range(10, 40);
            else
                run_len = $urandom_range(150, 300);
            m_axis_tready <= 1'b1;
            repeat (run_len) begin
                @(posedge i_clk);
                if (m_axis_tvalid && m_axis_tready)
                    results_taken++;
            end
            stall_len = pick_pause(1);
            m_axis_tready <= 1'b0;
            repeat (stall_len) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [31:0] edge_cases [$];
        edge_cases = '{
            32'd0,            // epoch, a Saturday
            32'd59,           // last second of the first minute
            32'd60,           // minute carry
            32'd3599,         // last second of the first hour
            32'd3600,         // hour carry
            32'd86399,        // 23:59:59 on the first day
            32'd86400,        // first Sunday
            32'd5097599,      // Feb 28 2000, last second
            32'd5097600,      // Feb 29 2000
            32'd5184000,      // Mar 1 2000
            32'd31622399,     // Dec 31 2000, last second
            32'd31622400,     // Jan 1 2001
            32'd36719999,     // Feb 28 2001, last second of a non-leap February
            32'd36720000,     // Mar 1 2001
            32'd3155759999,   // Dec 31 2099, last second
            32'd3155760000,   // Jan 1 2100, past the valid range
            32'd3160857600,   // Feb 29 2100, leap rule applied without century fix
            32'h7FFF_FFFF,
            32'h8000_0000,
            32'h5555_5555,
            32'hAAAA_AAAA,
            32'hFFFF_FFFF     // largest count, year offset 136
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed edge cases, back to back
        foreach (edge_cases[i])
            send_stamp(edge_cases[i], 0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_stamp(random_stamp(), pick_pause(0));
        s_axis_tvalid <= 1'b0;

        // Drain: sample on the falling edge, away from the checker's updates
        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: ends the run as failed if the stimulus has not finished
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> timestamp_to_calendar.f
hdl/tsc_pkg.sv
hdl/tsc_urom.sv
hdl/tsc_dpath.sv
hdl/timestamp_to_calendar.sv
bench/tsc_calendar_checker.sv
bench/tb_timestamp_to_calendar.sv
